// File: rtl/dbcm_pkg.sv
// Shared types, constants and helpers for the detection box cluster merge unit.
package dbcm_pkg;

  // Largest number of candidates held for one set.
  localparam int MaxCandDefault = 32;

  // Field widths.
  localparam int CoordW = 12;
  localparam int ScoreW = 31;
  localparam int SizeW  = 13;
  localparam int MembW  = 6;

  // Configuration register indexes.
  localparam logic [1:0] RegBoxWidth   = 2'd0;
  localparam logic [1:0] RegBoxHeight  = 2'd1;
  localparam logic [1:0] RegScoreWin   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CoordW-1:0] BoxWidthReset  = 12'd64;
  localparam logic [CoordW-1:0] BoxHeightReset = 12'd64;
  localparam logic [ScoreW-1:0] ScoreWinReset  = 31'd180;

  // Result kinds.
  localparam logic KindCand    = 1'b0;
  localparam logic KindCluster = 1'b1;

  // One stored candidate.
  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } cand_t;

  // One cluster: representative, bounds and member count.
  typedef struct packed {
    logic [MembW-1:0]  size;
    logic [CoordW-1:0] max_y;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] rep_y;
    logic [CoordW-1:0] rep_x;
  } clus_t;

  localparam int CandW = $bits(cand_t);
  localparam int ClusW = $bits(clus_t);

  // Absolute difference of two coordinates.
  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: rtl/detection_box_cluster_merge_unit.sv
// Top level: collects candidates, ranks them, clusters them and emits boxes.
// While idle the block loads one candidate per cycle. After the final candidate a run
// follows: each rank scans the store entry by entry, a read then one shared compare per
// entry; each kept candidate then scans clusters, a read then a check per cluster; and
// each cluster is merged in a read, an x step and a y step. The block takes no candidate
// during a run. Reset is synchronous, active low.
module detection_box_cluster_merge_unit import dbcm_pkg::*; #(
  parameter int MAX_CANDIDATES = MaxCandDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // Candidate stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cand_x[11:0], cand_y[23:12], cand_score[54:24]
  input  logic        in_tlast,   // last_cand
  // Box stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // box_x[11:0], box_y[23:12], box_w[36:24],
                                  // box_h[49:37], overflowed[50]
  output logic        out_tuser,  // box_kind
  output logic        out_tlast,  // last_box
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SSEL  = 4'd1;
  localparam logic [3:0] S_SREAD = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_SDONE = 4'd4;
  localparam logic [3:0] S_EMIT0 = 4'd5;
  localparam logic [3:0] S_CREAD = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_MREAD = 4'd8;
  localparam logic [3:0] S_MX    = 4'd9;
  localparam logic [3:0] S_MY    = 4'd10;

  // Configuration registers.
  logic [CoordW-1:0] box_w_r, box_h_r;
  logic [ScoreW-1:0] win_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_w_r <= BoxWidthReset;
      box_h_r <= BoxHeightReset;
      win_r   <= ScoreWinReset;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        RegBoxWidth:  box_w_r <= cfg_pwdata[CoordW-1:0];
        RegBoxHeight: box_h_r <= cfg_pwdata[CoordW-1:0];
        RegScoreWin:  win_r   <= cfg_pwdata[ScoreW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[3:2])
      RegBoxWidth:  cfg_prdata = {20'd0, box_w_r};
      RegBoxHeight: cfg_prdata = {20'd0, box_h_r};
      RegScoreWin:  cfg_prdata = {1'b0, win_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer and datapath registers.
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic [CNT_W-1:0]  sj_r, sj_nxt;
  logic [CNT_W-1:0]  nclus_r, nclus_nxt;
  logic [CNT_W-1:0]  cj_r, cj_nxt;
  logic              hb_r, hb_nxt;
  cand_t             best_r, best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [ScoreW-1:0] prev_s_r, prev_s_nxt;
  logic [IDX_W-1:0]  prev_idx_r, prev_idx_nxt;
  logic [ScoreW:0]   limit_r, limit_nxt;
  logic [CoordW-1:0] mx_start_r, mx_start_nxt;
  logic [SizeW-1:0]  mx_len_r, mx_len_nxt;

  // Output register.
  logic              ov_r, ov_nxt;
  logic              ok_r, ok_nxt;
  logic              ol_r, ol_nxt;
  logic [CoordW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [SizeW-1:0]  ow_r, ow_nxt, oh_r, oh_nxt;
  logic              oovf_r, oovf_nxt;
  logic              out_free;

  // Memory ports.
  logic              cw_en, cr_en;
  logic [IDX_W-1:0]  cw_addr, cr_addr;
  cand_t             cw_data, cr_data;
  logic              kw_en, kr_en;
  logic [IDX_W-1:0]  kw_addr, kr_addr;
  clus_t             kw_data, kr_data;

  // Shared axis unit.
  logic [CoordW-1:0] ax_lo, ax_hi, ax_size, ax_start;
  logic [SizeW-1:0]  ax_len;

  // Working values.
  cand_t                   in_cand;
  logic                    in_acc;
  logic [ScoreW+IDX_W-1:0] key_c;
  logic                    above_prev, below_best, match;
  logic [ScoreW:0]         lim;

  assign in_cand.x     = in_tdata[11:0];
  assign in_cand.y     = in_tdata[23:12];
  assign in_cand.score = in_tdata[54:24];
  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;
  assign out_free      = !ov_r || out_tready;

  // Candidate store.
  dbcm_ram #(.DEPTH(MAX_CANDIDATES), .AW(IDX_W), .DW(CandW)) u_cand_mem (
    .clk     (clk),
    .wr_en   (cw_en),
    .wr_addr (cw_addr),
    .wr_data (cw_data),
    .rd_en   (cr_en),
    .rd_addr (cr_addr),
    .rd_data (cr_data)
  );

  // Cluster store.
  dbcm_ram #(.DEPTH(MAX_CANDIDATES), .AW(IDX_W), .DW(ClusW)) u_clus_mem (
    .clk     (clk),
    .wr_en   (kw_en),
    .wr_addr (kw_addr),
    .wr_data (kw_data),
    .rd_en   (kr_en),
    .rd_addr (kr_addr),
    .rd_data (kr_data)
  );

  // One axis merge unit, used for x and then for y.
  assign ax_lo   = (state_r == S_MX) ? kr_data.min_x : kr_data.min_y;
  assign ax_hi   = (state_r == S_MX) ? kr_data.max_x : kr_data.max_y;
  assign ax_size = (state_r == S_MX) ? box_w_r : box_h_r;

  dbcm_axis u_axis (
    .lo      (ax_lo),
    .hi      (ax_hi),
    .size    (ax_size),
    .members (kr_data.size),
    .start   (ax_start),
    .len     (ax_len)
  );

  // Ranking compare: score first, then arrival order.
  assign key_c      = {cr_data.score, sj_r[IDX_W-1:0]};
  assign above_prev = (rank_r == '0) || (key_c > {prev_s_r, prev_idx_r});
  assign below_best = !hb_r || (key_c < {best_r.score, best_idx_r});
  assign lim        = (rank_r == '0) ? ({1'b0, best_r.score} + {1'b0, win_r}) : limit_r;
  assign match      = (abs_diff(best_r.x, kr_data.rep_x) <= box_w_r) &&
                      (abs_diff(best_r.y, kr_data.rep_y) <= box_h_r);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    drop_nxt     = drop_r;
    rank_nxt     = rank_r;
    sj_nxt       = sj_r;
    nclus_nxt    = nclus_r;
    cj_nxt       = cj_r;
    hb_nxt       = hb_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    prev_s_nxt   = prev_s_r;
    prev_idx_nxt = prev_idx_r;
    limit_nxt    = limit_r;
    mx_start_nxt = mx_start_r;
    mx_len_nxt   = mx_len_r;
    ov_nxt       = ov_r && !out_tready;
    ok_nxt       = ok_r;
    ol_nxt       = ol_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    ow_nxt       = ow_r;
    oh_nxt       = oh_r;
    oovf_nxt     = oovf_r;
    cw_en        = 1'b0;
    cw_addr      = count_r[IDX_W-1:0];
    cw_data      = in_cand;
    cr_en        = 1'b0;
    cr_addr      = sj_r[IDX_W-1:0];
    kw_en        = 1'b0;
    kw_addr      = cj_r[IDX_W-1:0];
    kw_data      = kr_data;
    kr_en        = 1'b0;
    kr_addr      = cj_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_CANDIDATES)) begin
            cw_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            rank_nxt  = '0;
            nclus_nxt = '0;
            state_nxt = S_SSEL;
          end
        end
      end

      // Start the scan for the next rank, or go to merging.
      S_SSEL: begin
        if (rank_r == count_r) begin
          cj_nxt    = '0;
          state_nxt = S_MREAD;
        end else begin
          sj_nxt    = '0;
          hb_nxt    = 1'b0;
          state_nxt = S_SREAD;
        end
      end

      S_SREAD: begin
        cr_en     = 1'b1;
        state_nxt = S_SCMP;
      end

      // Keep the smallest key that lies above the previous rank's key.
      S_SCMP: begin
        if (above_prev && below_best) begin
          hb_nxt       = 1'b1;
          best_nxt     = cr_data;
          best_idx_nxt = sj_r[IDX_W-1:0];
        end
        sj_nxt    = sj_r + 1'b1;
        state_nxt = (sj_r + 1'b1 == count_r) ? S_SDONE : S_SREAD;
      end

      // Apply the score window; sorted order means the first miss ends the pass.
      S_SDONE: begin
        limit_nxt    = lim;
        prev_s_nxt   = best_r.score;
        prev_idx_nxt = best_idx_r;
        rank_nxt     = rank_r + 1'b1;
        if ({1'b0, best_r.score} > lim) begin
          cj_nxt    = '0;
          state_nxt = S_MREAD;
        end else begin
          state_nxt = S_EMIT0;
        end
      end

      // Emit the kept candidate's own box.
      S_EMIT0: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = KindCand;
          ol_nxt    = 1'b0;
          ox_nxt    = best_r.x;
          oy_nxt    = best_r.y;
          ow_nxt    = {1'b0, box_w_r};
          oh_nxt    = {1'b0, box_h_r};
          oovf_nxt  = drop_r;
          cj_nxt    = '0;
          state_nxt = S_CREAD;
        end
      end

      // Search clusters in creation order, or open a new one.
      S_CREAD: begin
        if (cj_r == nclus_r) begin
          kw_en         = 1'b1;
          kw_data.rep_x = best_r.x;
          kw_data.rep_y = best_r.y;
          kw_data.min_x = best_r.x;
          kw_data.max_x = best_r.x;
          kw_data.min_y = best_r.y;
          kw_data.max_y = best_r.y;
          kw_data.size  = MembW'(1);
          nclus_nxt     = nclus_r + 1'b1;
          state_nxt     = S_SSEL;
        end else begin
          kr_en     = 1'b1;
          state_nxt = S_CCHK;
        end
      end

      S_CCHK: begin
        if (match) begin
          kw_en = 1'b1;
          if (best_r.x < kr_data.min_x) kw_data.min_x = best_r.x;
          if (best_r.x > kr_data.max_x) kw_data.max_x = best_r.x;
          if (best_r.y < kr_data.min_y) kw_data.min_y = best_r.y;
          if (best_r.y > kr_data.max_y) kw_data.max_y = best_r.y;
          kw_data.size = kr_data.size + 1'b1;
          state_nxt    = S_SSEL;
        end else begin
          cj_nxt    = cj_r + 1'b1;
          state_nxt = S_CREAD;
        end
      end

      // Merge each cluster in creation order; the run ends after the last.
      S_MREAD: begin
        if (cj_r == nclus_r) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          kr_en     = 1'b1;
          state_nxt = S_MX;
        end
      end

      S_MX: begin
        mx_start_nxt = ax_start;
        mx_len_nxt   = ax_len;
        state_nxt    = S_MY;
      end

      S_MY: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = KindCluster;
          ol_nxt    = (cj_r + 1'b1 == nclus_r);
          ox_nxt    = mx_start_r;
          oy_nxt    = ax_start;
          ow_nxt    = mx_len_r;
          oh_nxt    = ax_len;
          oovf_nxt  = drop_r;
          cj_nxt    = cj_r + 1'b1;
          state_nxt = S_MREAD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      rank_r  <= '0;
      nclus_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      rank_r  <= rank_nxt;
      nclus_r <= nclus_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sj_r       <= sj_nxt;
    cj_r       <= cj_nxt;
    hb_r       <= hb_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    prev_s_r   <= prev_s_nxt;
    prev_idx_r <= prev_idx_nxt;
    limit_r    <= limit_nxt;
    mx_start_r <= mx_start_nxt;
    mx_len_r   <= mx_len_nxt;
    ok_r       <= ok_nxt;
    ol_r       <= ol_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    ow_r       <= ow_nxt;
    oh_r       <= oh_nxt;
    oovf_r     <= oovf_nxt;
  end

  // Result stream.
  assign out_tvalid = ov_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {5'd0, oovf_r, oh_r, ow_r, oy_r, ox_r};

endmodule

// File: rtl/dbcm_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module dbcm_ram import dbcm_pkg::*; #(
  parameter int DEPTH = MaxCandDefault,
  parameter int AW    = 5,
  parameter int DW    = CandW
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/dbcm_axis.sv
// Merges one cluster axis into start and length, shrinking wide clusters of 3+ members.
module dbcm_axis import dbcm_pkg::*; (
  input  logic [CoordW-1:0] lo,
  input  logic [CoordW-1:0] hi,
  input  logic [CoordW-1:0] size,
  input  logic [MembW-1:0]  members,
  output logic [CoordW-1:0] start,
  output logic [SizeW-1:0]  len
);

  logic [27:0]       third_prod;
  logic [CoordW-1:0] third;
  logic [13:0]       span;
  logic              shrink;
  logic [13:0]       start_w;
  logic [13:0]       len_w;

  // Size divided by three, by multiplying with a scaled reciprocal.
  assign third_prod = {16'd0, size} * 28'd43691;
  assign third      = {1'b0, third_prod[27:17]};

  // Span of the union of the windows on this axis.
  assign span   = {2'd0, hi} - {2'd0, lo} + {2'd0, size};
  assign shrink = (members >= MembW'(3)) &&
                  ({span, 1'b0} >= ({1'b0, size, 1'b0} + {3'd0, size}));

  // Move both corners inward by a third of the size when shrinking.
  always_comb begin
    if (shrink) begin
      start_w = {2'd0, lo} + {2'd0, third};
      len_w   = span - {1'b0, third, 1'b0};
    end else begin
      start_w = {2'd0, lo};
      len_w   = span;
    end
  end

  assign start = start_w[CoordW-1:0];
  assign len   = len_w[SizeW-1:0];

endmodule
